### hw/rtl/lpht_pkg.sv
`timescale 1ns / 1ps

package lpht_pkg;

  // Table geometry. The home slot is the low bits of the key.
  localparam int unsigned TABLE_SIZE = 64;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);

  localparam int unsigned KEY_W = 32;
  localparam int unsigned IDX_FIELD_W = 16;

  // Operation codes of an input transaction.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_FIND   = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_INSERTED = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_FOUND    = 2'd2;
  localparam logic [1:0] STATUS_MISSING  = 2'd3;

  typedef logic [IDX_W-1:0] slot_idx_t;

  // Payload stored in one slot.
  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [IDX_FIELD_W-1:0] row;
    logic [IDX_FIELD_W-1:0] col;
  } slot_entry_t;

  // Access request from the probe controller to the slot memory.
  typedef struct packed {
    logic        rd_en;
    slot_idx_t   rd_addr;
    logic        wr_en;
    slot_idx_t   wr_addr;
    slot_entry_t wr_entry;
  } mem_req_t;

  // Registered read data, valid in the cycle after the read request.
  typedef struct packed {
    logic        valid;
    slot_entry_t entry;
  } mem_rsp_t;

endpackage

### hw/rtl/lpht_if.sv
`timescale 1ns / 1ps

// Operation channel: insert or find.
interface lpht_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] key;
  logic [15:0] row_index;
  logic [15:0] col_index;

  modport source (output valid, output kind, output key, output row_index,
                  output col_index, input ready);
  modport sink   (input valid, input kind, input key, input row_index,
                  input col_index, output ready);
endinterface

// Result channel: one transaction per operation.
interface lpht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] found_row;
  logic [15:0] found_col;

  modport source (output valid, output status, output found_row, output found_col,
                  input ready);
  modport sink   (input valid, input status, input found_row, input found_col,
                  output ready);
endinterface

### hw/rtl/linear_probe_hash_table_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields                              Handshake
// req_i     in   kind, key, row_index, col_index    valid / ready
// rsp_o     out  status, found_row, found_col       valid / ready
//
// An operation probes N slots (1 to 64): the slot memory gives one read per cycle
// while the output is not stalled, and is the limit.
// req_i.ready is high whenever no operation is probing, also while a result
// still waits in the output register; a probe that ends against a stalled
// output holds until the result register frees. Reset clears all occupancy
// bits at once; no clearing pass is needed.

module linear_probe_hash_table_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpht_req_if.sink   req_i,
  lpht_rsp_if.source rsp_o
);
  import lpht_pkg::*;

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  // Probe sequencer and result register.
  lpht_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .mem_req_o (mem_req),
    .mem_rsp_i (mem_rsp)
  );

  // Slot storage.
  lpht_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rsp_o  (mem_rsp)
  );

endmodule

### hw/rtl/lpht_mem.sv
`timescale 1ns / 1ps

module lpht_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpht_pkg::mem_req_t req_i,
  output lpht_pkg::mem_rsp_t rsp_o
);
  import lpht_pkg::*;

  slot_entry_t            mem_q [TABLE_SIZE];
  logic [TABLE_SIZE-1:0]  valid_q;
  logic                   rd_valid_q;
  slot_entry_t            rd_entry_q;

  // Slot payload memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_entry;
    end
    if (req_i.rd_en) begin
      rd_entry_q <= mem_q[req_i.rd_addr];
    end
  end

  // Occupancy bits, cleared at reset, read alongside the payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rsp_o.valid = rd_valid_q;
  assign rsp_o.entry = rd_entry_q;

endmodule

### hw/rtl/lpht_ctrl.sv
`timescale 1ns / 1ps

module lpht_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  lpht_req_if.sink           req_i,
  lpht_rsp_if.source         rsp_o,
  output lpht_pkg::mem_req_t mem_req_o,
  input  lpht_pkg::mem_rsp_t mem_rsp_i
);
  import lpht_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_PROBE = 1'b1;

  logic                   state_q, state_d;
  logic                   kind_q, kind_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [IDX_FIELD_W-1:0] row_q, row_d;
  logic [IDX_FIELD_W-1:0] col_q, col_d;
  slot_idx_t              idx_q, idx_d;
  slot_idx_t              cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             out_status_q, out_status_d;
  logic [IDX_FIELD_W-1:0] out_row_q, out_row_d;
  logic [IDX_FIELD_W-1:0] out_col_q, out_col_d;

  logic      req_fire;
  logic      out_free;
  logic      last_probe;
  logic      hit;
  logic      done;
  slot_idx_t next_idx;
  slot_idx_t home_idx;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign home_idx    = IDX_W'(req_i.key % TABLE_SIZE);
  assign last_probe  = (cnt_q == IDX_W'(TABLE_SIZE - 1));
  assign next_idx    = (idx_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_q + 1'b1;
  assign hit         = mem_rsp_i.valid && (mem_rsp_i.entry.key == key_q);

  // A probe ends at an empty slot, at a matching key on find, or after the last slot.
  assign done = !mem_rsp_i.valid || last_probe || ((kind_q == KIND_FIND) && hit);

  // Probe sequencer: one slot per cycle while the output is not stalled, next read issued while this one is checked.
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    key_d        = key_q;
    row_d        = row_q;
    col_d        = col_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;

    mem_req_o                = '0;
    mem_req_o.wr_addr        = idx_q;
    mem_req_o.wr_entry.key   = key_q;
    mem_req_o.wr_entry.row   = row_q;
    mem_req_o.wr_entry.col   = col_q;
    mem_req_o.rd_addr        = next_idx;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          kind_d            = req_i.kind;
          key_d             = req_i.key;
          row_d             = req_i.row_index;
          col_d             = req_i.col_index;
          idx_d             = home_idx;
          cnt_d             = '0;
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = home_idx;
          state_d           = S_PROBE;
        end
      end
      S_PROBE: begin
        if (done) begin
          // Finish only when the output register can take the result.
          if (out_free) begin
            out_valid_d = 1'b1;
            out_row_d   = '0;
            out_col_d   = '0;
            if (kind_q == KIND_INSERT) begin
              out_status_d    = mem_rsp_i.valid ? STATUS_FULL : STATUS_INSERTED;
              mem_req_o.wr_en = !mem_rsp_i.valid;
            end else if (hit) begin
              out_status_d = STATUS_FOUND;
              out_row_d    = mem_rsp_i.entry.row;
              out_col_d    = mem_rsp_i.entry.col;
            end else begin
              out_status_d = STATUS_MISSING;
            end
            state_d = S_IDLE;
          end
        end else begin
          mem_req_o.rd_en = 1'b1;
          idx_d           = next_idx;
          cnt_d           = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    key_q        <= key_d;
    row_q        <= row_d;
    col_q        <= col_d;
    idx_q        <= idx_d;
    cnt_q        <= cnt_d;
    out_status_q <= out_status_d;
    out_row_q    <= out_row_d;
    out_col_q    <= out_col_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.found_row = out_row_q;
  assign rsp_o.found_col = out_col_q;

  // A slot is written only by an insert that ends in the probe state.
  a_wr_in_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> (state_q == S_PROBE) && (kind_q == KIND_INSERT))
    else $error("slot write outside an insert probe");

  // Reading and writing never overlap, so no forwarding is needed.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.rd_en && mem_req_o.wr_en))
    else $error("slot read and write in the same cycle");

  // A new result appears only at the end of a probe.
  a_result_from_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_PROBE)
    else $error("result without a probe");

  // An accepted operation always starts probing with a read of its home slot.
  a_accept_reads_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |-> mem_req_o.rd_en ##1 (state_q == S_PROBE) && (cnt_q == '0))
    else $error("operation accepted without a home slot read");

endmodule
